### rtl/sptg_pkg.sv
// shared types and constants of the spectral peak track grouper
package sptg_pkg;

   // field widths of the item, result and register channels
   localparam int TIME_W = 16;
   localparam int FREQ_W = 12;
   localparam int CSR_W  = 8;
   localparam int CSR_IDX_W = 2;

   // most results one flush reports
   localparam int RESULT_CAP = 32;
   localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

   // groups holding this many peaks or fewer are pruned when stale
   localparam logic [1:0] SMALL_GROUP = 2'd2;
   localparam logic [1:0] COUNT_SAT   = 2'd3;

   // item opcodes
   localparam logic OP_PEAK  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_BELOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_ABOVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_SAME  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN     = 2'd3;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_SCAN      = 4'b0010,
      ST_FLUSH     = 4'b0100,
      ST_FLUSH_END = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic prune;
      logic take;
      logic advance;
      logic alloc;
      logic fl_step;
      logic emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
      logic at_end;
      logic prune;
      logic match;
      logic qualify;
      logic cap;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

### rtl/sptg_ctrl.sv
// controller state machine of the spectral peak track grouper
module sptg_ctrl
   import sptg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_opcode == OP_FLUSH) begin
                  state_in = ST_FLUSH;
               end else if (status.in_range) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (status.at_end) begin
               cmd.alloc = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.prune) begin
               cmd.prune = 1'b1;
            end else if (status.match) begin
               cmd.take = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FLUSH: begin
            priority if (status.at_end || status.cap) begin
               state_in = ST_FLUSH_END;
            end else if (status.qualify && status.pend_valid && !status.out_free) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.fl_step = 1'b1;
            end
         end
         ST_FLUSH_END: begin
            if (status.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/sptg_datapath.sv
// group table, scan pointer, pending box and result register
module sptg_datapath
   import sptg_pkg::*;
#(
   parameter int MAX_GROUPS = 32,
   parameter int FREQ_BINS  = 4096,
   parameter int TIME_STEPS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TIME_W-1:0]    req_time_index,
   input  logic [FREQ_W-1:0]    req_freq_bin,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_group_found,
   output logic [TIME_W-1:0]    rsp_first_time,
   output logic [TIME_W-1:0]    rsp_final_time,
   output logic [FREQ_W-1:0]    rsp_low_freq,
   output logic [FREQ_W-1:0]    rsp_high_freq,
   output logic                 rsp_overflowed,
   output logic                 rsp_last_result
);

   localparam int SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);

   // configuration
   logic [CSR_W-1:0] margin_below_ff, margin_above_ff, margin_same_ff, min_span_ff;

   // group table
   logic [MAX_GROUPS-1:0] valid_ff;
   logic [SW-1:0]         order_ff     [MAX_GROUPS];
   logic [TIME_W-1:0]     first_ff     [MAX_GROUPS];
   logic [TIME_W-1:0]     last_ff      [MAX_GROUPS];
   logic [FREQ_W-1:0]     minf_ff      [MAX_GROUPS];
   logic [FREQ_W-1:0]     maxf_ff      [MAX_GROUPS];
   logic [FREQ_W-1:0]     rowlo_ff     [MAX_GROUPS];
   logic [FREQ_W-1:0]     rowhi_ff     [MAX_GROUPS];
   logic [1:0]            count_ff     [MAX_GROUPS];

   logic [CW-1:0]         n_ff, r_ff;
   logic [RES_CNT_W-1:0]  res_cnt_ff;
   logic                  drop_ff;
   logic [TIME_W-1:0]     item_t_ff;
   logic [FREQ_W-1:0]     item_f_ff;

   // box waiting to learn whether it is the last one
   logic                  pend_valid_ff;
   logic [TIME_W-1:0]     pend_first_ff, pend_final_ff;
   logic [FREQ_W-1:0]     pend_low_ff, pend_high_ff;

   // result register
   logic                  rsp_valid_ff, rsp_found_ff, rsp_over_ff, rsp_last_ff;
   logic [TIME_W-1:0]     rsp_first_ff, rsp_final_ff;
   logic [FREQ_W-1:0]     rsp_low_ff, rsp_high_ff;

   logic [SW-1:0]         cur_s, free_s;
   logic                  free_found;
   logic [TIME_W-1:0]     cur_first, cur_last, span;
   logic [FREQ_W-1:0]     cur_lo, cur_hi;
   logic [1:0]            cur_count;
   logic [TIME_W:0]       t17, lt1;
   logic [FREQ_W:0]       f13, lo13, hi13;
   logic                  next_row, same_row, next_ok, same_ok;
   logic                  push, out_free;

   // current group under the scan pointer
   assign cur_s     = order_ff[r_ff[SW-1:0]];
   assign cur_first = first_ff[cur_s];
   assign cur_last  = last_ff[cur_s];
   assign cur_lo    = rowlo_ff[cur_s];
   assign cur_hi    = rowhi_ff[cur_s];
   assign cur_count = count_ff[cur_s];

   // time and frequency windows
   assign t17  = {1'b0, item_t_ff};
   assign lt1  = {1'b0, cur_last} + 17'd1;
   assign f13  = {1'b0, item_f_ff};
   assign lo13 = {1'b0, cur_lo};
   assign hi13 = {1'b0, cur_hi};
   assign next_row = (lt1 == t17);
   assign same_row = (cur_last == item_t_ff);
   assign next_ok  = next_row && (f13 + {5'd0, margin_below_ff} >= lo13)
                              && (f13 <= hi13 + {5'd0, margin_above_ff});
   assign same_ok  = same_row && (f13 + {5'd0, margin_same_ff} >= lo13)
                              && (f13 <= hi13 + {5'd0, margin_same_ff});
   assign span     = cur_last - cur_first;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_s     = '0;
      for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_s     = SW'(i);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // status to the controller
   always_comb begin
      status            = '0;
      status.in_range   = (32'(req_freq_bin) < 32'(FREQ_BINS)) &&
                          (32'(req_time_index) < 32'(TIME_STEPS));
      status.at_end     = (r_ff == n_ff);
      status.prune      = (lt1 < t17) && (cur_count <= SMALL_GROUP);
      status.match      = next_ok || same_ok;
      status.qualify    = (cur_last >= cur_first) && (span >= {8'd0, min_span_ff});
      status.cap        = (res_cnt_ff == RES_CNT_W'(RESULT_CAP));
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   assign push = (cmd.fl_step && status.qualify && pend_valid_ff) || cmd.emit_last;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         n_ff            <= '0;
         r_ff            <= '0;
         res_cnt_ff      <= '0;
         drop_ff         <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         margin_below_ff <= 8'd1;
         margin_above_ff <= 8'd3;
         margin_same_ff  <= 8'd1;
         min_span_ff     <= 8'd2;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MARGIN_BELOW: margin_below_ff <= csr_write_data;
               CSR_MARGIN_ABOVE: margin_above_ff <= csr_write_data;
               CSR_MARGIN_SAME:  margin_same_ff  <= csr_write_data;
               CSR_MIN_SPAN:     min_span_ff     <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.capture) begin
            r_ff <= '0;
         end
         if (cmd.prune) begin
            valid_ff[cur_s] <= 1'b0;
            n_ff            <= n_ff - CW'(1);
         end
         if (cmd.advance) begin
            r_ff <= r_ff + CW'(1);
         end
         if (cmd.alloc) begin
            if (free_found) begin
               valid_ff[free_s] <= 1'b1;
               n_ff             <= n_ff + CW'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (cmd.fl_step) begin
            r_ff <= r_ff + CW'(1);
            if (status.qualify) begin
               pend_valid_ff <= 1'b1;
               res_cnt_ff    <= res_cnt_ff + RES_CNT_W'(1);
            end
         end
         if (cmd.emit_last) begin
            valid_ff      <= '0;
            n_ff          <= '0;
            drop_ff       <= 1'b0;
            pend_valid_ff <= 1'b0;
            res_cnt_ff    <= '0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // table contents, pending box and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_t_ff <= req_time_index;
         item_f_ff <= req_freq_bin;
      end
      // close the gap left by a pruned group
      if (cmd.prune) begin
         for (int k = 0; k < MAX_GROUPS - 1; k++) begin
            if (CW'(k) >= r_ff) begin
               order_ff[k] <= order_ff[k + 1];
            end
         end
      end
      // peak joins the current group
      if (cmd.take) begin
         if (next_row) begin
            rowlo_ff[cur_s] <= item_f_ff;
            rowhi_ff[cur_s] <= item_f_ff;
            last_ff[cur_s]  <= item_t_ff;
         end else begin
            if (item_f_ff < cur_lo) rowlo_ff[cur_s] <= item_f_ff;
            if (item_f_ff > cur_hi) rowhi_ff[cur_s] <= item_f_ff;
         end
         if (item_f_ff < minf_ff[cur_s]) minf_ff[cur_s] <= item_f_ff;
         if (item_f_ff > maxf_ff[cur_s]) maxf_ff[cur_s] <= item_f_ff;
         if (cur_count != COUNT_SAT) count_ff[cur_s] <= cur_count + 2'd1;
      end
      // peak opens a new group
      if (cmd.alloc && free_found) begin
         first_ff[free_s]           <= item_t_ff;
         last_ff[free_s]            <= item_t_ff;
         minf_ff[free_s]            <= item_f_ff;
         maxf_ff[free_s]            <= item_f_ff;
         rowlo_ff[free_s]           <= item_f_ff;
         rowhi_ff[free_s]           <= item_f_ff;
         count_ff[free_s]           <= 2'd1;
         order_ff[n_ff[SW-1:0]]     <= free_s;
      end
      // flush: qualifying box goes to pending, previous pending goes out
      if (cmd.fl_step && status.qualify) begin
         pend_first_ff <= cur_first;
         pend_final_ff <= cur_last;
         pend_low_ff   <= minf_ff[cur_s];
         pend_high_ff  <= maxf_ff[cur_s];
      end
      if (push) begin
         rsp_found_ff <= cmd.emit_last ? pend_valid_ff : 1'b1;
         rsp_first_ff <= (cmd.emit_last && !pend_valid_ff) ? '0 : pend_first_ff;
         rsp_final_ff <= (cmd.emit_last && !pend_valid_ff) ? '0 : pend_final_ff;
         rsp_low_ff   <= (cmd.emit_last && !pend_valid_ff) ? '0 : pend_low_ff;
         rsp_high_ff  <= (cmd.emit_last && !pend_valid_ff) ? '0 : pend_high_ff;
         rsp_over_ff  <= drop_ff;
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group_found = rsp_found_ff;
   assign rsp_first_time  = rsp_first_ff;
   assign rsp_final_time  = rsp_final_ff;
   assign rsp_low_freq    = rsp_low_ff;
   assign rsp_high_freq   = rsp_high_ff;
   assign rsp_overflowed  = rsp_over_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

### rtl/spectral_peak_track_grouper.sv
// top level of the spectral peak track grouper
// Groups spectrogram peaks into time-frequency tracks. A peak item walks the
// group table in creation order, one group per cycle, pruning small stale
// groups and stopping at the first group that takes it, or opening a new
// group after the last one if a slot is free; a peak outside the table's
// time or frequency range is ignored. A flush visits the live groups in
// turn, one per cycle while the result side does not stall, stopping early
// once the result cap is reached, and reports qualifying boxes through a
// one-deep result register, the final box flagged last. Inputs are stalled
// while an item is at work.
module spectral_peak_track_grouper
   import sptg_pkg::*;
#(
   parameter int MAX_GROUPS = 32,
   parameter int FREQ_BINS  = 4096,
   parameter int TIME_STEPS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [TIME_W-1:0]    req_time_index,
   input  logic [FREQ_W-1:0]    req_freq_bin,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_group_found,
   output logic [TIME_W-1:0]    rsp_first_time,
   output logic [TIME_W-1:0]    rsp_final_time,
   output logic [FREQ_W-1:0]    rsp_low_freq,
   output logic [FREQ_W-1:0]    rsp_high_freq,
   output logic                 rsp_overflowed,
   output logic                 rsp_last_result,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // controller
   sptg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   sptg_datapath #(
      .MAX_GROUPS (MAX_GROUPS),
      .FREQ_BINS  (FREQ_BINS),
      .TIME_STEPS (TIME_STEPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_time_index  (req_time_index),
      .req_freq_bin    (req_freq_bin),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_group_found (rsp_group_found),
      .rsp_first_time  (rsp_first_time),
      .rsp_final_time  (rsp_final_time),
      .rsp_low_freq    (rsp_low_freq),
      .rsp_high_freq   (rsp_high_freq),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   // a finished flush leaves a last result on the output
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (rsp_valid && rsp_last_result))
      else $error("flush end did not present a last result");

   // the block is free for a new item right after a flush ends
   a_idle_after_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> !req_stall)
      else $error("block still busy after flush");

   // one table action per cycle
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.prune, cmd.take, cmd.advance, cmd.alloc}))
      else $error("conflicting table commands");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.emit_last || (cmd.fl_step && status.qualify
                                    && status.pend_valid)))
      else $error("result overwritten while stalled");
`endif

endmodule
